### rtl/adctw_pkg.sv
`default_nettype none

package adctw_pkg;

    localparam int DATA_BITS_DEF = 24;

    localparam int PULSE_W = 16;
    localparam int MAXRD_W = 32;
    localparam int GAIN_W  = 3;
    localparam int TICK_W  = 32;
    localparam int CFG_W   = 32;
    localparam int CIDX_W  = 2;

    localparam logic [CIDX_W-1:0] CFG_PULSE_TICKS    = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_MAX_READ_TICKS = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_GAIN_PULSES    = 2'd2;

    localparam logic [PULSE_W-1:0] PULSE_RST = 16'd10;
    localparam logic [MAXRD_W-1:0] MAXRD_RST = 32'd20000;
    localparam logic [GAIN_W-1:0]  GAIN_RST  = 3'd1;
    localparam logic [GAIN_W-1:0]  GAIN_MAX  = 3'd4;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HIGH,
        PH_LOW
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK,
        ST_NOT_READY,
        ST_TIMEOUT,
        ST_DESYNC
    } t_status;

    typedef struct packed {
        logic [PULSE_W-1:0] pulse_ticks;
        logic [MAXRD_W-1:0] max_read_ticks;
        logic [GAIN_W-1:0]  gain_pulses;
    } t_cfg;

endpackage

`default_nettype wire

### rtl/adctw_step.sv
`default_nettype none

module adctw_step #(
    parameter int DATA_BITS = adctw_pkg::DATA_BITS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_adv,
    input  wire logic                        i_start,
    input  wire logic                        i_data,
    input  wire adctw_pkg::t_cfg             i_cfg,
    output logic                             o_clock_level,
    output logic                             o_result_valid,
    output adctw_pkg::t_status               o_status,
    output logic [DATA_BITS-1:0]             o_sample_value,
    output logic [adctw_pkg::TICK_W-1:0]     o_sample_time
);

    localparam int IDX_W = $clog2(DATA_BITS + 5);
    localparam int TW    = adctw_pkg::TICK_W;
    localparam int PW    = adctw_pkg::PULSE_W;
    localparam logic [DATA_BITS-1:0] TOP_CODE = {1'b1, {(DATA_BITS-1){1'b0}}};

    adctw_pkg::t_phase   r_phase, n_phase;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic [PW-1:0]       r_timer, n_timer;
    logic [DATA_BITS-1:0] r_shift, n_shift;
    logic [TW-1:0]       r_start_time, n_start_time;
    logic [TW-1:0]       r_tick;

    logic [PW-1:0]       eff_pulse;
    logic [adctw_pkg::GAIN_W-1:0] eff_gain;
    logic [PW:0]         timer_inc;
    logic [IDX_W-1:0]    idx_inc;
    logic [TW-1:0]       elapsed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= adctw_pkg::PH_IDLE;
            r_idx        <= '0;
            r_timer      <= '0;
            r_shift      <= '0;
            r_start_time <= '0;
            r_tick       <= '0;
        end else if (i_adv) begin
            r_phase      <= n_phase;
            r_idx        <= n_idx;
            r_timer      <= n_timer;
            r_shift      <= n_shift;
            r_start_time <= n_start_time;
            r_tick       <= r_tick + 1'b1;
        end
    end

    always_comb begin
        eff_pulse = (i_cfg.pulse_ticks == '0) ? PW'(1) : i_cfg.pulse_ticks;
        if (i_cfg.gain_pulses == '0) begin
            eff_gain = adctw_pkg::GAIN_W'(1);
        end else if (i_cfg.gain_pulses > adctw_pkg::GAIN_MAX) begin
            eff_gain = adctw_pkg::GAIN_MAX;
        end else begin
            eff_gain = i_cfg.gain_pulses;
        end

        n_phase        = r_phase;
        n_idx          = r_idx;
        n_timer        = r_timer;
        n_shift        = r_shift;
        n_start_time   = r_start_time;
        o_clock_level  = 1'b0;
        o_result_valid = 1'b0;
        o_status       = adctw_pkg::ST_OK;
        o_sample_value = '0;
        o_sample_time  = '0;

        // a start while idle either answers not ready or opens the first high phase
        if (r_phase == adctw_pkg::PH_IDLE && i_start) begin
            if (i_data) begin
                o_result_valid = 1'b1;
                o_status       = adctw_pkg::ST_NOT_READY;
                o_sample_time  = r_tick;
            end else begin
                n_start_time = r_tick;
                n_idx        = '0;
                n_shift      = '0;
                n_timer      = '0;
                n_phase      = adctw_pkg::PH_HIGH;
            end
        end

        timer_inc = {1'b0, n_timer} + 1'b1;
        idx_inc   = n_idx + 1'b1;
        elapsed   = r_tick - n_start_time;

        unique case (n_phase)
            adctw_pkg::PH_IDLE: begin
            end
            adctw_pkg::PH_HIGH: begin
                o_clock_level = 1'b1;
                if (timer_inc >= {1'b0, eff_pulse}) begin
                    n_phase = adctw_pkg::PH_LOW;
                    n_timer = '0;
                end else begin
                    n_timer = timer_inc[PW-1:0];
                end
            end
            adctw_pkg::PH_LOW: begin
                if (timer_inc >= {1'b0, eff_pulse}) begin
                    n_timer = '0;
                    // shift MSB first on the last tick of each of the first DATA_BITS low phases
                    if (n_idx < IDX_W'(DATA_BITS)) begin
                        n_shift = {n_shift[DATA_BITS-2:0], i_data};
                    end
                    if (idx_inc >= IDX_W'(DATA_BITS) + IDX_W'(eff_gain)) begin
                        o_result_valid = 1'b1;
                        o_sample_time  = n_start_time;
                        // timeout check wins over desync
                        if (elapsed > i_cfg.max_read_ticks) begin
                            o_status = adctw_pkg::ST_TIMEOUT;
                        end else if (!i_data || n_shift == TOP_CODE) begin
                            o_status = adctw_pkg::ST_DESYNC;
                        end else begin
                            o_status       = adctw_pkg::ST_OK;
                            o_sample_value = n_shift;
                        end
                        n_phase = adctw_pkg::PH_IDLE;
                        n_idx   = '0;
                    end else begin
                        n_phase = adctw_pkg::PH_HIGH;
                        n_idx   = idx_inc;
                    end
                end else begin
                    n_timer = timer_inc[PW-1:0];
                end
            end
            default: begin
                n_phase = adctw_pkg::PH_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/adc_two_wire_serial_reader_core.sv
`default_nettype none

// An accepted input word passes the input register and the result register to the master side.
// One input and one result word per cycle unless stalled; every input word gives one result.
// The input register and the result register each stall only while the next stage is full.
// Reset (synchronous, active low) empties both stages, clears the tick counter and read state,
// and loads the configuration registers with their default values.
module adc_two_wire_serial_reader_core #(
    parameter int DATA_BITS = adctw_pkg::DATA_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // slave side
    input  wire logic                           i_s_tvalid,
    output logic                                o_s_tready,
    input  wire logic [7:0]                     i_s_tdata,  // [0] data_level
    input  wire logic                           i_s_tuser,  // [0] start_read
    // master side
    output logic                                o_m_tvalid,
    input  wire logic                           i_m_tready,
    // [0] clock_level, [DATA_BITS:1] sample_value, [DATA_BITS+32:DATA_BITS+1] sample_time
    output logic [((DATA_BITS+40)/8)*8-1:0]     o_m_tdata,
    output logic [2:0]                          o_m_tuser,  // [0] result_valid, [2:1] status
    // configuration
    input  wire logic                           i_cfg_we,
    input  wire logic [adctw_pkg::CIDX_W-1:0]   i_cfg_index,
    input  wire logic [adctw_pkg::CFG_W-1:0]    i_cfg_data
);

    localparam int OUT_BITS = 1 + DATA_BITS + adctw_pkg::TICK_W;
    localparam int TDATA_W  = ((DATA_BITS + 40) / 8) * 8;

    adctw_pkg::t_cfg r_cfg;

    logic r_in_valid;
    logic r_in_start;
    logic r_in_data;
    logic r_out_valid;
    logic [OUT_BITS-1:0] r_out_data;
    logic [2:0]          r_out_user;

    logic out_ready;
    logic adv;

    logic                          step_clk;
    logic                          step_valid;
    adctw_pkg::t_status            step_status;
    logic [DATA_BITS-1:0]          step_value;
    logic [adctw_pkg::TICK_W-1:0]  step_time;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pulse_ticks    <= adctw_pkg::PULSE_RST;
            r_cfg.max_read_ticks <= adctw_pkg::MAXRD_RST;
            r_cfg.gain_pulses    <= adctw_pkg::GAIN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                adctw_pkg::CFG_PULSE_TICKS:
                    r_cfg.pulse_ticks <= i_cfg_data[adctw_pkg::PULSE_W-1:0];
                adctw_pkg::CFG_MAX_READ_TICKS:
                    r_cfg.max_read_ticks <= i_cfg_data[adctw_pkg::MAXRD_W-1:0];
                adctw_pkg::CFG_GAIN_PULSES:
                    r_cfg.gain_pulses <= i_cfg_data[adctw_pkg::GAIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign out_ready  = !r_out_valid || i_m_tready;
    assign adv        = r_in_valid && out_ready;
    assign o_s_tready = !r_in_valid || out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    // hold the input word while the result register is full and the master side is not ready
    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_start <= i_s_tuser;
            r_in_data  <= i_s_tdata[0];
        end
    end

    adctw_step #(
        .DATA_BITS(DATA_BITS)
    ) u_step (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_adv          (adv),
        .i_start        (r_in_start),
        .i_data         (r_in_data),
        .i_cfg          (r_cfg),
        .o_clock_level  (step_clk),
        .o_result_valid (step_valid),
        .o_status       (step_status),
        .o_sample_value (step_value),
        .o_sample_time  (step_time)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_data <= {step_time, step_value, step_clk};
            r_out_user <= {step_status, step_valid};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = TDATA_W'(r_out_data);
    assign o_m_tuser  = r_out_user;

endmodule

`default_nettype wire
